FILE: src/utf8d_pkg.sv
package utf8d_pkg;

    localparam logic [20:0] REPL_CHAR    = 21'h00FFFD;
    localparam logic [20:0] MIN_TWO      = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [20:0] MIN_FOUR     = 21'h010000;
    localparam logic [20:0] SURR_LOW     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;

    // Lengths of an open sequence as held in expected_reg
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // All results caused by one byte: a run of replacements, then at most
    // one decoded value.
    typedef struct packed {
        logic [2:0]  repl_count;
        logic        has_value;
        logic [20:0] code_point;
        logic [2:0]  width;
    } utf8d_entry_t;

endpackage

FILE: src/utf8d_front.sv
module utf8d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_string,
    output logic                   push,
    output utf8d_pkg::utf8d_entry_t entry
);
    import utf8d_pkg::*;

    logic [7:0] held_bytes_reg [0:2];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] expected_reg;
    logic [2:0] expected_next;

    logic        is_cont;
    logic [2:0]  lead_len;
    logic [2:0]  seq_len;
    logic [20:0] seq_value;
    logic        seq_ok;
    logic        hold_wr;
    logic [1:0]  hold_idx;
    logic        emit;

    assign is_cont = (data_byte[7:6] == 2'b10);
    assign seq_len = {1'b0, held_count_reg} + LEN_ONE;

    always_comb
    begin
        if (data_byte[7:5] == 3'b110)
            lead_len = LEN_TWO;
        else if (data_byte[7:4] == 4'b1110)
            lead_len = LEN_THREE;
        else if (data_byte[7:3] == 5'b11110)
            lead_len = LEN_FOUR;
        else
            lead_len = LEN_NONE;
    end

    // Assemble and check the sequence that the arriving byte would complete
    always_comb
    begin
        seq_value = '0;
        seq_ok    = 1'b0;
        unique case (held_count_reg)
            2'd1:
            begin
                seq_value = {10'd0, held_bytes_reg[0][4:0], data_byte[5:0]};
                seq_ok    = (seq_value >= MIN_TWO);
            end
            2'd2:
            begin
                seq_value = {5'd0, held_bytes_reg[0][3:0], held_bytes_reg[1][5:0],
                             data_byte[5:0]};
                seq_ok    = (seq_value >= MIN_THREE) &&
                            ((seq_value < SURR_LOW) || (seq_value > SURR_HIGH));
            end
            2'd3:
            begin
                seq_value = {held_bytes_reg[0][2:0], held_bytes_reg[1][5:0],
                             held_bytes_reg[2][5:0], data_byte[5:0]};
                seq_ok    = (seq_value >= MIN_FOUR) && (seq_value <= MAX_SCALAR);
            end
            default:
            begin
                seq_value = '0;
                seq_ok    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry           = '0;
        hold_wr         = 1'b0;
        hold_idx        = 2'd0;
        held_count_next = held_count_reg;
        expected_next   = expected_reg;

        if ((held_count_reg != 2'd0) && is_cont)
        begin
            if (seq_len >= expected_reg)
            begin
                if (seq_ok)
                begin
                    entry.has_value  = 1'b1;
                    entry.code_point = seq_value;
                    entry.width      = seq_len;
                end
                else
                begin
                    entry.repl_count = seq_len;
                end
                held_count_next = 2'd0;
                expected_next   = LEN_NONE;
            end
            else
            begin
                hold_wr         = 1'b1;
                hold_idx        = held_count_reg;
                held_count_next = seq_len[1:0];
                if (end_of_string)
                begin
                    entry.repl_count = seq_len;
                    held_count_next  = 2'd0;
                    expected_next    = LEN_NONE;
                end
            end
        end
        else
        begin
            // Flush an interrupted sequence, then decode the byte afresh
            entry.repl_count = {1'b0, held_count_reg};
            held_count_next  = 2'd0;
            expected_next    = LEN_NONE;
            if (data_byte[7] == 1'b0)
            begin
                entry.has_value  = 1'b1;
                entry.code_point = {13'd0, data_byte};
                entry.width      = LEN_ONE;
            end
            else if ((lead_len != LEN_NONE) && !end_of_string)
            begin
                hold_wr         = 1'b1;
                hold_idx        = 2'd0;
                held_count_next = 2'd1;
                expected_next   = lead_len;
            end
            else
            begin
                entry.repl_count = entry.repl_count + 3'd1;
            end
        end
    end

    assign emit = (entry.repl_count != 3'd0) || entry.has_value;
    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            expected_reg   <= LEN_NONE;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            expected_reg   <= expected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_wr)
            held_bytes_reg[hold_idx] <= data_byte;
    end

    a_open_short : assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd0) |-> (expected_reg > {1'b0, held_count_reg}))
        else $error("open sequence already holds its full length");

    a_idle_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg == 2'd0) |-> (expected_reg == LEN_NONE))
        else $error("expected length left without a held byte");

    a_eos_flush : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_string) |=> (held_count_reg == 2'd0))
        else $error("bytes still held after end of string");

endmodule

FILE: src/utf8d_queue.sv
module utf8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  utf8d_pkg::utf8d_entry_t push_entry,
    input  logic                    pop,
    output utf8d_pkg::utf8d_entry_t head_entry,
    output logic                    not_empty,
    output logic                    not_full
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf8d_entry_t     slots_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_entry = slots_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    assign not_full   = (count_reg != FULL_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("push into a full queue");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

FILE: src/utf8d_back.sv
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::utf8d_entry_t head_entry,
    input  logic                    head_valid,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [20:0]             code_point,
    output logic                    invalid,
    output logic [2:0]              source_width,
    output logic                    last
);
    import utf8d_pkg::*;

    utf8d_entry_t cur_reg;
    logic         cur_valid_reg;
    logic [2:0]   repl_left_reg;

    logic in_repl;
    logic fire;
    logic done;

    assign in_repl      = (repl_left_reg != 3'd0);
    assign out_valid    = cur_valid_reg;
    assign code_point   = in_repl ? REPL_CHAR : cur_reg.code_point;
    assign invalid      = in_repl;
    assign source_width = in_repl ? LEN_ONE : cur_reg.width;
    assign last         = cur_reg.has_value ? !in_repl : (repl_left_reg == 3'd1);

    assign fire = cur_valid_reg && out_ready;
    assign done = !cur_valid_reg || (fire && last);
    assign pop  = done && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            repl_left_reg <= 3'd0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            repl_left_reg <= head_entry.repl_count;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            repl_left_reg <= repl_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_entry;
    end

    a_nonempty_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_repl || cur_reg.has_value))
        else $error("result shown for an entry with nothing left");

endmodule

FILE: src/utf8_decode_with_replacement.sv
// Streaming UTF-8 decoder with U+FFFD replacement. One byte is taken per cycle
// whenever the result queue has room (in_ready), and a byte that only opens or
// extends a sequence produces no result. Each result leaves in its own output
// handshake, so a byte that causes k results holds the output until all k have
// left; plain text runs at one byte and one result per cycle while out_ready
// stays high, and the QUEUE_DEPTH-entry queue between the byte classifier and
// the result sequencer absorbs bursts of replacements. The first result of a
// byte is written to a queue slot and then loaded into the sequencer's current
// entry register before it is offered. A replacement always reports
// source_width 1, and last marks the final result that one input byte causes.
module utf8_decode_with_replacement #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        invalid,
    output logic [2:0]  source_width,
    output logic        last
);
    import utf8d_pkg::*;

    utf8d_entry_t push_entry;
    utf8d_entry_t head_entry;
    logic         accept;
    logic         push;
    logic         pop;
    logic         head_valid;
    logic         not_full;

    assign in_ready = not_full;
    assign accept   = in_valid && in_ready;

    utf8d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .entry         (push_entry)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .not_empty  (head_valid),
        .not_full   (not_full)
    );

    utf8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_point   (code_point),
        .invalid      (invalid),
        .source_width (source_width),
        .last         (last)
    );

endmodule

FILE: verif/utf8_decode_checker.sv
`timescale 1ns / 100ps

module utf8_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [20:0] code_point,
    input  logic        invalid,
    input  logic [2:0]  source_width,
    input  logic        last,
    output int          errors,
    output int          pending
);
    import utf8d_pkg::*;

    typedef struct {
        logic [20:0] cp;
        logic        bad;
        logic [2:0]  width;
        logic        last;
    } decoded_cp_t;

    decoded_cp_t expected_cps[$];
    decoded_cp_t step_results[$];

    logic [7:0] held [3];
    logic [1:0] held_cnt = 2'd0;
    logic [2:0] seq_len  = LEN_NONE;
    int         fail_count = 0;
    int         pending_count = 0;

    assign errors  = fail_count;
    assign pending = pending_count;

    task automatic add_result(input logic [20:0] cp, input logic bad, input logic [2:0] w);
        decoded_cp_t r;
        r.cp    = cp;
        r.bad   = bad;
        r.width = w;
        r.last  = 1'b0;
        step_results.push_back(r);
    endtask

    // Drop every held byte as a replacement and close the sequence
    task automatic drop_held();
        int i;
        for (i = 0; i < held_cnt; i++)
            add_result(REPL_CHAR, 1'b1, LEN_ONE);
        held_cnt = 2'd0;
        seq_len  = LEN_NONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [7:0]  seq [4];
        logic [2:0]  n;
        logic [20:0] v;
        logic        ok;
        logic [2:0]  lead_len;
        logic        taken;
        decoded_cp_t r;
        int          i;
        step_results.delete();
        taken = 1'b0;
        if (held_cnt != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                taken = 1'b1;
                n = {1'b0, held_cnt} + 3'd1;
                if (n >= seq_len)
                begin
                    for (i = 0; i < held_cnt; i++)
                        seq[i] = held[i];
                    seq[n - 3'd1] = b;
                    if (n == LEN_TWO)
                    begin
                        v  = {10'd0, seq[0][4:0], seq[1][5:0]};
                        ok = (v >= MIN_TWO);
                    end
                    else if (n == LEN_THREE)
                    begin
                        v  = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
                        ok = (v >= MIN_THREE) && (v < SURR_LOW || v > SURR_HIGH);
                    end
                    else
                    begin
                        v  = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
                        ok = (v >= MIN_FOUR) && (v <= MAX_SCALAR);
                    end
                    if (ok)
                        add_result(v, 1'b0, n);
                    else
                        for (i = 0; i < n; i++)
                            add_result(REPL_CHAR, 1'b1, LEN_ONE);
                    held_cnt = 2'd0;
                    seq_len  = LEN_NONE;
                end
                else
                begin
                    held[held_cnt] = b;
                    held_cnt = held_cnt + 2'd1;
                    // Cut off by the end mark: the new byte goes out with the rest
                    if (eos)
                        drop_held();
                end
            end
            else
            begin
                drop_held();
            end
        end
        if (!taken)
        begin
            if (b[7] == 1'b0)
            begin
                add_result({13'd0, b}, 1'b0, LEN_ONE);
            end
            else
            begin
                if (b[7:5] == 3'b110)
                    lead_len = LEN_TWO;
                else if (b[7:4] == 4'b1110)
                    lead_len = LEN_THREE;
                else if (b[7:3] == 5'b11110)
                    lead_len = LEN_FOUR;
                else
                    lead_len = LEN_NONE;
                if (lead_len == LEN_NONE || eos)
                begin
                    add_result(REPL_CHAR, 1'b1, LEN_ONE);
                end
                else
                begin
                    held[0]  = b;
                    held_cnt = 2'd1;
                    seq_len  = lead_len;
                end
            end
        end
        foreach (step_results[k])
        begin
            r = step_results[k];
            r.last = (k == step_results.size() - 1);
            expected_cps.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_cp_t exp_cp;
        if (!rst_n)
        begin
            held_cnt = 2'd0;
            seq_len  = LEN_NONE;
            expected_cps.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cps.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("utf8 check: unexpected result cp=%h inv=%b w=%0d last=%b",
                                 code_point, invalid, source_width, last);
                    fail_count++;
                end
                else
                begin
                    exp_cp = expected_cps.pop_front();
                    if (code_point !== exp_cp.cp || invalid !== exp_cp.bad ||
                        source_width !== exp_cp.width || last !== exp_cp.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("utf8 check: mismatch expected cp=%h inv=%b w=%0d last=%b",
                                     exp_cp.cp, exp_cp.bad, exp_cp.width, exp_cp.last);
                            $display("utf8 check: mismatch got      cp=%h inv=%b w=%0d last=%b",
                                     code_point, invalid, source_width, last);
                        end
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_string);
        end
        pending_count = expected_cps.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int IDLE_LIMIT  = 1000;
    localparam int BYTE_TARGET = 270;
    localparam int HOLD_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_string;
    logic        out_valid;
    logic        out_ready;
    logic [20:0] code_point;
    logic        invalid;
    logic [2:0]  source_width;
    logic        last;

    int          mismatch_total;
    int          results_due;
    int          burst_left;
    int          bytes_sent;
    logic        hold_req;
    logic [7:0]  char_bytes[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    utf8_decode_with_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .invalid       (invalid),
        .source_width  (source_width),
        .last          (last)
    );

    utf8_decode_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .invalid       (invalid),
        .source_width  (source_width),
        .last          (last),
        .errors        (mismatch_total),
        .pending       (results_due)
    );

    // Hold valid and payload until the request is taken; return at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic e);
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic offer(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_byte(b, e);
    endtask

    task automatic encode_cp(input logic [20:0] cp, input int len);
        case (len)
            2:
            begin
                char_bytes.push_back({3'b110, cp[10:6]});
                char_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                char_bytes.push_back({4'b1110, cp[15:12]});
                char_bytes.push_back({2'b10, cp[11:6]});
                char_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                char_bytes.push_back({5'b11110, cp[20:18]});
                char_bytes.push_back({2'b10, cp[17:12]});
                char_bytes.push_back({2'b10, cp[11:6]});
                char_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] scalar_for_len(input int len);
        if (len == 2)
            return 21'($urandom_range(21'h80, 21'h7FF));
        else if (len == 3)
            return 21'($urandom_range(21'h800, 21'hFFFF));
        else
            return 21'($urandom_range(21'h10000, 21'h10FFFF));
    endfunction

    // One character of the random stream: mostly well formed, some broken
    task automatic emit_char();
        int         kind;
        int         len;
        int         i;
        logic [20:0] cp;
        logic       eos_last;
        char_bytes.delete();
        kind     = $urandom_range(0, 99);
        eos_last = ($urandom_range(0, 7) == 0);
        if (kind < 30)
        begin
            char_bytes.push_back(8'($urandom_range(0, 127)));
        end
        else if (kind < 72)
        begin
            len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
            encode_cp(scalar_for_len(len), len);
        end
        else if (kind < 78)
        begin
            // Overlong form
            len = $urandom_range(2, 4);
            if (len == 2)
                cp = 21'($urandom_range(0, 21'h7F));
            else if (len == 3)
                cp = 21'($urandom_range(0, 21'h7FF));
            else
                cp = 21'($urandom_range(0, 21'hFFFF));
            encode_cp(cp, len);
        end
        else if (kind < 82)
        begin
            encode_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        end
        else if (kind < 88)
        begin
            // Truncate; the next lead interrupts or the end mark cuts it off
            len = $urandom_range(2, 4);
            encode_cp(scalar_for_len(len), len);
            repeat ($urandom_range(1, len - 1))
                void'(char_bytes.pop_back());
            eos_last = ($urandom_range(0, 1) == 1);
        end
        else if (kind < 94)
        begin
            char_bytes.push_back(8'($urandom_range(0, 255)));
            eos_last = ($urandom_range(0, 3) == 0);
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                char_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else
                char_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end
        for (i = 0; i < char_bytes.size(); i++)
            offer(char_bytes[i], eos_last && (i == char_bytes.size() - 1));
    endtask

    // Receiver: the stall pattern switches among four modes, each held for a random run
    initial
    begin : receiver
        int   mode;
        int   mode_left;
        int   phase;
        logic hold_done;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // Hold off long enough for the block to fill and stall its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 64);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= phase[0];
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic paused;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        end_of_string = 1'b0;
        rst_n         = 1'b0;
        hold_req      = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        paused        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ASCII extremes, the second with the end mark
        offer(8'h00, 1'b0);
        offer(8'h7F, 1'b1);
        // Two byte lowest and highest
        offer(8'hC2, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'hDF, 1'b0);
        offer(8'hBF, 1'b0);
        // Overlong two byte
        offer(8'hC0, 1'b0);
        offer(8'h80, 1'b0);
        // Surrogate
        offer(8'hED, 1'b0);
        offer(8'hA0, 1'b0);
        offer(8'h80, 1'b0);
        // Highest scalar, then one above it
        offer(8'hF4, 1'b0);
        offer(8'h8F, 1'b0);
        offer(8'hBF, 1'b0);
        offer(8'hBF, 1'b0);
        offer(8'hF4, 1'b0);
        offer(8'h90, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'h80, 1'b0);
        // Stray continuation and bad lead
        offer(8'h80, 1'b0);
        offer(8'hFF, 1'b0);
        // Interrupted by a plain byte
        offer(8'hE2, 1'b0);
        offer(8'h41, 1'b0);
        // Cut off by the end mark, then a lead that carries the end mark
        offer(8'hF0, 1'b0);
        offer(8'h90, 1'b1);
        offer(8'hC3, 1'b1);

        in_valid <= 1'b0;
        wait (results_due == 0);
        @(negedge clk);

        while (bytes_sent < BYTE_TARGET)
        begin
            if (bytes_sent >= 100)
                hold_req <= 1'b1;
            if (!paused && bytes_sent >= 190)
            begin
                // Pause until every expected result has drained
                in_valid <= 1'b0;
                wait (results_due == 0);
                @(negedge clk);
                paused = 1'b1;
            end
            emit_char();
        end

        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (20) @(negedge clk);
        if (mismatch_total == 0 && results_due == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
